// File: design/piq_pkg.sv
package piq_pkg;

    // Number of cells in the queue.
    localparam int DEPTH = 16;

    // Field widths.
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 8;
    localparam int ID_W     = 16;
    localparam int TYPE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Count must hold DEPTH itself; a cell index only DEPTH-1.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   req_id;
        logic [TYPE_W-1:0] req_type;
    } t_entry;

    // Command broadcast to every cell at once.
    typedef struct packed {
        logic             shift_in;
        logic             shift_out;
        logic [CNT_W-1:0] pos;
    } t_cell_cmd;

endpackage

// File: design/piq_cell.sv
module piq_cell (
    input  logic                      i_clk,
    input  logic [piq_pkg::IDX_W-1:0] i_index,
    input  piq_pkg::t_cell_cmd        i_cmd,
    input  piq_pkg::t_entry           i_new,
    input  piq_pkg::t_entry           i_left,
    input  piq_pkg::t_entry           i_right,
    output piq_pkg::t_entry           o_entry
);

    piq_pkg::t_entry                  r_entry;
    piq_pkg::t_entry                  n_entry;
    logic [piq_pkg::CNT_W-1:0]        idx;

    assign idx = piq_pkg::CNT_W'(i_index);

    // A remove pulls the right neighbour in; an insert keeps cells ahead of the
    // position, loads the new entry at it and pulls the left neighbour behind it.
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.shift_out) begin
            n_entry = i_right;
        end else if (i_cmd.shift_in) begin
            if (idx == i_cmd.pos) begin
                n_entry = i_new;
            end else if (idx > i_cmd.pos) begin
                n_entry = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: design/positional_insert_queue.sv
// The result of a transaction is registered and presented in the cycle after it is accepted.
// One transaction per cycle while the output is not stalled; the whole row of cells shifts at once.
// The input stalls only while a finished result is held and the output is stalled.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// the cell contents are not cleared, as no cell at or beyond the count is read.
module positional_insert_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [piq_pkg::FUNC_W-1:0]   i_func,
    input  logic [piq_pkg::POS_W-1:0]    i_position,
    input  logic [piq_pkg::ID_W-1:0]     i_req_id,
    input  logic [piq_pkg::TYPE_W-1:0]   i_req_type,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [piq_pkg::STATUS_W-1:0] o_status,
    output logic [piq_pkg::ID_W-1:0]     o_out_id,
    output logic [piq_pkg::TYPE_W-1:0]   o_out_type,
    output logic [piq_pkg::OCC_W-1:0]    o_occupancy
);

    localparam int CMP_W = piq_pkg::CNT_W + piq_pkg::POS_W;
    localparam int EXT_W = piq_pkg::CNT_W + piq_pkg::OCC_W;

    // Control state.
    logic                         r_valid;
    logic                         n_valid;
    logic [piq_pkg::CNT_W-1:0]    r_count;
    logic [piq_pkg::CNT_W-1:0]    n_count;

    // Result register, a payload holding stage between the two sides.
    logic [piq_pkg::STATUS_W-1:0] r_status;
    logic [piq_pkg::STATUS_W-1:0] n_status;
    logic [piq_pkg::ID_W-1:0]     r_out_id;
    logic [piq_pkg::ID_W-1:0]     n_out_id;
    logic [piq_pkg::TYPE_W-1:0]   r_out_type;
    logic [piq_pkg::TYPE_W-1:0]   n_out_type;
    logic [piq_pkg::OCC_W-1:0]    r_occupancy;
    logic [piq_pkg::OCC_W-1:0]    n_occupancy;

    logic                         accept;
    logic                         is_full;
    logic                         is_empty;
    logic [CMP_W-1:0]             pos_wide;
    logic [CMP_W-1:0]             cnt_wide;
    logic [piq_pkg::CNT_W-1:0]    ins_pos;
    logic [EXT_W-1:0]             count_ext;
    piq_pkg::t_cell_cmd           cmd;
    piq_pkg::t_entry              new_entry;
    piq_pkg::t_entry              cell_q [piq_pkg::DEPTH];

    // A new transaction is taken whenever the result register is empty or its
    // contents are being taken in this very cycle.
    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    assign is_full  = (r_count == piq_pkg::CNT_W'(piq_pkg::DEPTH));
    assign is_empty = (r_count == '0);

    // The insert position is clamped to the count, so that a position past the
    // tail simply appends.
    assign pos_wide = CMP_W'(i_position);
    assign cnt_wide = CMP_W'(r_count);
    assign ins_pos  = (pos_wide > cnt_wide) ? r_count : piq_pkg::CNT_W'(i_position);

    assign new_entry.req_id   = i_req_id;
    assign new_entry.req_type = i_req_type;

    // Decode the operation into the broadcast cell command, the next count and
    // the result fields. A full queue refuses both kinds of entry; the spare
    // operation code changes nothing and reports success.
    always_comb begin
        cmd.shift_in  = 1'b0;
        cmd.shift_out = 1'b0;
        cmd.pos       = r_count;
        n_count       = r_count;
        n_status      = piq_pkg::ST_OK;
        n_out_id      = '0;
        n_out_type    = '0;
        unique case (i_func)
            piq_pkg::FUNC_APPEND,
            piq_pkg::FUNC_INSERT: begin
                if (is_full) begin
                    n_status = piq_pkg::ST_FULL;
                end else begin
                    cmd.shift_in = accept;
                    cmd.pos      = (i_func == piq_pkg::FUNC_APPEND) ? r_count : ins_pos;
                    n_count      = r_count + piq_pkg::CNT_W'(1);
                end
            end
            piq_pkg::FUNC_REMOVE: begin
                if (is_empty) begin
                    n_status = piq_pkg::ST_EMPTY;
                end else begin
                    cmd.shift_out = accept;
                    n_out_id      = cell_q[0].req_id;
                    n_out_type    = cell_q[0].req_type;
                    n_count       = r_count - piq_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // The occupancy field carries the low bits of the count after the step.
    assign count_ext   = EXT_W'(n_count);
    assign n_occupancy = count_ext[piq_pkg::OCC_W-1:0];

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_out_id    <= n_out_id;
            r_out_type  <= n_out_type;
            r_occupancy <= n_occupancy;
        end
    end

    // The row of cells: cell 0 is the head. Each cell sees both neighbours; the
    // ends take a filler that is never selected for a live entry.
    for (genvar k = 0; k < piq_pkg::DEPTH; k++) begin : g_cell
        piq_pkg::t_entry left_in;
        piq_pkg::t_entry right_in;

        if (k == 0) begin : g_head
            assign left_in = new_entry;
        end else begin : g_mid_l
            assign left_in = cell_q[k-1];
        end

        if (k == piq_pkg::DEPTH - 1) begin : g_tail
            assign right_in = cell_q[k];
        end else begin : g_mid_r
            assign right_in = cell_q[k+1];
        end

        piq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (piq_pkg::IDX_W'(k)),
            .i_cmd   (cmd),
            .i_new   (new_entry),
            .i_left  (left_in),
            .i_right (right_in),
            .o_entry (cell_q[k])
        );
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_out_type  = r_out_type;
    assign o_occupancy = r_occupancy;

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= piq_pkg::CNT_W'(piq_pkg::DEPTH))
        else $error("queue count exceeds depth");

    // An accepted transaction always leaves a result in the output register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("accepted transaction produced no result");

    // A refusal for lack of room is only reported while every cell is in use.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == piq_pkg::ST_FULL) |-> is_full)
        else $error("full status reported with free cells");

    // An empty report leaves the queue empty.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == piq_pkg::ST_EMPTY) |-> is_empty)
        else $error("empty status reported with entries held");

    // A cell shift only happens when a transaction is taken.
    a_shift_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.shift_in || cmd.shift_out) |-> accept)
        else $error("cells shifted without an accepted transaction");

endmodule

// File: tb/tb_positional_insert_queue.sv
`timescale 1ns / 100ps

module tb_positional_insert_queue;

    // The fourth selector value has no operation behind it. The block must
    // leave the queue untouched and answer ok with the current occupancy.
    localparam logic [piq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Length of the deliberate hold-off on the result side, in clock cycles.
    localparam int HOLD_CYCLES   = 60;
    // Quiet cycles after the last result before the verdict is given.
    localparam int SETTLE_CYCLES = 8;
    // Number of random request transactions after the directed part.
    localparam int RANDOM_ITEMS  = 830;
    // Absolute limit on the run, in ns. This is far above the slowest correct run.
    localparam int unsigned TIMEOUT_NS = 2_000_000;

    // One request transaction, as offered on the input channel.
    typedef struct packed {
        logic [piq_pkg::FUNC_W-1:0] func;
        logic [piq_pkg::POS_W-1:0]  position;
        logic [piq_pkg::ID_W-1:0]   req_id;
        logic [piq_pkg::TYPE_W-1:0] req_type;
    } t_request;

    // One result transaction, as presented on the output channel.
    typedef struct packed {
        logic [piq_pkg::STATUS_W-1:0] status;
        logic [piq_pkg::ID_W-1:0]     out_id;
        logic [piq_pkg::TYPE_W-1:0]   out_type;
        logic [piq_pkg::OCC_W-1:0]    occupancy;
    } t_outcome;

    // The random part moves between phases that mostly add entries, phases
    // that mostly remove them, and an even mix. This takes the queue to both
    // full and empty many times.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // ------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the queue contents, works out
    // the outcome of every accepted request and compares each result
    // transaction against the oldest outcome still awaited.
    // ------------------------------------------------------------------
    class queue_scoreboard;
        piq_pkg::t_entry contents[$];
        t_outcome        awaited[$];
        int              fail_count;

        function new();
            fail_count = 0;
        endfunction

        function void note_request(t_request req);
            t_outcome        res;
            piq_pkg::t_entry item;
            int              slot;
            res           = '0;
            res.status    = piq_pkg::ST_OK;
            item.req_id   = req.req_id;
            item.req_type = req.req_type;
            case (req.func)
                piq_pkg::FUNC_APPEND, piq_pkg::FUNC_INSERT: begin
                    if (contents.size() >= piq_pkg::DEPTH) begin
                        // A full queue refuses the entry and keeps its state.
                        res.status = piq_pkg::ST_FULL;
                    end else begin
                        // An append goes to the tail. An insert position beyond
                        // the count is clamped to the tail as well.
                        slot = contents.size();
                        if (req.func == piq_pkg::FUNC_INSERT &&
                            int'(req.position) < slot) begin
                            slot = int'(req.position);
                        end
                        contents.insert(slot, item);
                    end
                end
                piq_pkg::FUNC_REMOVE: begin
                    if (contents.size() == 0) begin
                        res.status = piq_pkg::ST_EMPTY;
                    end else begin
                        item         = contents.pop_front();
                        res.out_id   = item.req_id;
                        res.out_type = item.req_type;
                    end
                end
                default: begin
                end
            endcase
            res.occupancy = piq_pkg::OCC_W'(contents.size());
            awaited.push_back(res);
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (awaited.size() == 0) begin
                $error("result transaction arrived with no outcome awaited");
                fail_count++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                fail_count++;
            end
            if (got.out_id !== want.out_id) begin
                $error("out_id mismatch: expected 0x%04h, actual 0x%04h",
                       want.out_id, got.out_id);
                fail_count++;
            end
            if (got.out_type !== want.out_type) begin
                $error("out_type mismatch: expected 0x%02h, actual 0x%02h",
                       want.out_type, got.out_type);
                fail_count++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy mismatch: expected %0d, actual %0d",
                       want.occupancy, got.occupancy);
                fail_count++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [piq_pkg::FUNC_W-1:0]   i_func;
    logic [piq_pkg::POS_W-1:0]    i_position;
    logic [piq_pkg::ID_W-1:0]     i_req_id;
    logic [piq_pkg::TYPE_W-1:0]   i_req_type;
    logic                         o_valid;
    logic                         i_stall;
    logic [piq_pkg::STATUS_W-1:0] o_status;
    logic [piq_pkg::ID_W-1:0]     o_out_id;
    logic [piq_pkg::TYPE_W-1:0]   o_out_type;
    logic [piq_pkg::OCC_W-1:0]    o_occupancy;

    queue_scoreboard sb;

    // The stimulus process raises this flag to ask the result side for a long
    // hold-off. The result side clears it once it has started counting.
    bit hold_off_req;

    positional_insert_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_req_id    (i_req_id),
        .i_req_type  (i_req_type),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_out_type  (o_out_type),
        .o_occupancy (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Runaway guard: a stuck handshake ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("** positional_insert_queue: FAILED **");
        $finish;
    end

    function automatic t_request make_request(logic [piq_pkg::FUNC_W-1:0] func,
                                              logic [piq_pkg::POS_W-1:0]  pos,
                                              logic [piq_pkg::ID_W-1:0]   id,
                                              logic [piq_pkg::TYPE_W-1:0] kind);
        t_request req;
        req.func     = func;
        req.position = pos;
        req.req_id   = id;
        req.req_type = kind;
        return req;
    endfunction

    // Draws one request for the given phase. Insert positions mostly fall from
    // zero to one past the current count, so that head, middle and tail are all
    // exercised. Now and then a position is drawn over the whole field, so that
    // every bit toggles and the clamp to the tail is taken often.
    function automatic t_request random_request(t_mix mix, int held);
        t_request req;
        int       roll;
        int       add_pct;
        case (mix)
            MIX_FILL:  add_pct = 75;
            MIX_DRAIN: add_pct = 20;
            default:   add_pct = 48;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            req.func = FUNC_UNUSED;
        end else if (roll < 4 + add_pct) begin
            req.func = ($urandom_range(0, 1) == 0) ? piq_pkg::FUNC_APPEND
                                                   : piq_pkg::FUNC_INSERT;
        end else begin
            req.func = piq_pkg::FUNC_REMOVE;
        end
        if ($urandom_range(0, 3) == 0) begin
            req.position = piq_pkg::POS_W'($urandom_range(0, 255));
        end else begin
            req.position = piq_pkg::POS_W'($urandom_range(0, held + 1));
        end
        req.req_id   = piq_pkg::ID_W'($urandom_range(0, 65535));
        req.req_type = piq_pkg::TYPE_W'($urandom_range(0, 255));
        return req;
    endfunction

    // Offers one request and holds it steady until the block accepts it. The
    // task is entered just after a rising edge and returns just after the
    // accepting edge. The caller may then offer the next request at once.
    task automatic offer(t_request req);
        i_valid    <= 1'b1;
        i_func     <= req.func;
        i_position <= req.position;
        i_req_id   <= req.req_id;
        i_req_type <= req.req_type;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sb.note_request(req);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side. Each accepted result transaction is sampled at the rising
    // edge. The stall for the next cycle is then chosen. The stall pattern
    // runs in stretches of random length, and each stretch has its own stall
    // rate: some stretches never stall, others stall heavily. On request, a
    // long hold-off is counted down here so that the block fills and pushes
    // back on its input.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int run_left;
        int stall_pct;
        int hold_left;
        t_outcome got;
        run_left  = 0;
        stall_pct = 0;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.status    = o_status;
                got.out_id    = o_out_id;
                got.out_type  = o_out_type;
                got.occupancy = o_occupancy;
                sb.check_result(got);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 16);
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        default: stall_pct = 60;
                    endcase
                end
                run_left--;
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict.
    // ------------------------------------------------------------------
    initial begin : request_source
        t_request req;
        t_mix     mix;
        int       sent;
        int       burst;
        int       seg_left;
        int       k;

        sb           = new();
        hold_off_req = 1'b0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_func     <= piq_pkg::FUNC_APPEND;
        i_position <= '0;
        i_req_id   <= '0;
        i_req_type <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A remove on the empty queue and the unused selector
        // on the empty queue come first.
        offer(make_request(piq_pkg::FUNC_REMOVE, 8'd0, 16'hFFFF, 8'hFF));
        offer(make_request(FUNC_UNUSED, 8'd0, 16'h0000, 8'h00));
        // The extremes of the entry fields.
        offer(make_request(piq_pkg::FUNC_APPEND, 8'd0, 16'hFFFF, 8'hFF));
        offer(make_request(piq_pkg::FUNC_APPEND, 8'hFF, 16'h0000, 8'h00));
        // An insert at the head, one far beyond the count (clamped to the
        // tail), and one in the middle.
        offer(make_request(piq_pkg::FUNC_INSERT, 8'd0, 16'hA5A5, 8'h5A));
        offer(make_request(piq_pkg::FUNC_INSERT, 8'hFF, 16'h5A5A, 8'hA5));
        offer(make_request(piq_pkg::FUNC_INSERT, 8'd1, 16'h1234, 8'h81));
        // Fill the queue to the brim without gaps.
        for (k = 0; k < piq_pkg::DEPTH - 5; k++) begin
            offer(make_request(piq_pkg::FUNC_APPEND, 8'(k), 16'(16'h0100 + k),
                               8'(8'h10 + k)));
        end
        // On a full queue both kinds of add are refused. The unused selector
        // reports the full count.
        offer(make_request(piq_pkg::FUNC_APPEND, 8'd0, 16'hDEAD, 8'hEE));
        offer(make_request(piq_pkg::FUNC_INSERT, 8'd0, 16'hBEEF, 8'h11));
        offer(make_request(FUNC_UNUSED, 8'hFF, 16'hFFFF, 8'hFF));
        for (k = 0; k < 3; k++) begin
            offer(make_request(piq_pkg::FUNC_REMOVE, 8'd0, 16'h0000, 8'h00));
        end
        pause(3);

        // Random part. Bursts of random length are separated by random gaps,
        // and about a third of the gaps are empty. Twice the result side is
        // asked to hold off for a long stretch while a filling phase keeps
        // requests coming.
        sent     = 0;
        seg_left = 0;
        mix      = MIX_EVEN;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                if (sent == 250 || sent == 600) begin
                    hold_off_req = 1'b1;
                    mix          = MIX_FILL;
                    seg_left     = 40;
                end
                if (seg_left == 0) begin
                    case ($urandom_range(0, 2))
                        0:       mix = MIX_FILL;
                        1:       mix = MIX_DRAIN;
                        default: mix = MIX_EVEN;
                    endcase
                    seg_left = $urandom_range(20, 60);
                end
                seg_left--;
                req = random_request(mix, sb.contents.size());
                offer(req);
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                pause(0);
            end else begin
                pause($urandom_range(1, 8));
            end
        end
        i_valid <= 1'b0;

        // Wait for every awaited result, then let the pipeline settle.
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.fail_count == 0) begin
            $display("** positional_insert_queue: PASSED **");
        end else begin
            $display("** positional_insert_queue: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
design/piq_pkg.sv
design/piq_cell.sv
design/positional_insert_queue.sv
tb/tb_positional_insert_queue.sv
